>>> hdl/pid_controller_clamped_unit_macros.svh
// Assertion macros shared by the PID controller checker.
// No dependencies; included by name from files that assert.
`ifndef PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pidc_pkg.sv
// Shared types, constants and helpers for the PID controller.
// No dependencies; imported by every module of the block.
package pidc_pkg;

  localparam int DataW    = 32;
  localparam int DtW      = 24;
  localparam int IntW     = 64;
  localparam int FracW    = 16;
  localparam int NumW     = DataW + FracW;
  localparam int DivSteps = NumW;
  localparam int CntW     = $clog2(DivSteps + 1);
  localparam int RegIdxW  = 3;

  typedef logic [RegIdxW-1:0] reg_idx_t;

  // Configuration register indexes
  localparam reg_idx_t REG_KP      = reg_idx_t'(0);
  localparam reg_idx_t REG_KI      = reg_idx_t'(1);
  localparam reg_idx_t REG_KD      = reg_idx_t'(2);
  localparam reg_idx_t REG_OUT_MIN = reg_idx_t'(3);
  localparam reg_idx_t REG_OUT_MAX = reg_idx_t'(4);

  localparam logic signed [DataW-1:0] OUT_MIN_RST = -32'sd65536;
  localparam logic signed [DataW-1:0] OUT_MAX_RST = 32'sd65536;

  typedef struct packed {
    logic signed [DataW-1:0] error;
    logic [DtW-1:0]          dt;
  } pidc_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    skipped;
  } pidc_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_EDT, S_ACC_INT, S_MUL_KP, S_ACC_KP, S_MUL_KIL, S_ACC_KIL,
    S_MUL_KIH, S_ACC_KIH, S_WAIT_DIV, S_MUL_KD, S_ACC_KD, S_CLAMP_HI, S_PUT
  } pidc_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_MUL_EDT, OP_ACC_INT, OP_MUL_KP, OP_ACC_KP, OP_MUL_KIL,
    OP_ACC_KIL, OP_MUL_KIH, OP_ACC_KIH, OP_LATCH_DER, OP_MUL_KD, OP_ACC_KD,
    OP_CLAMP_HI
  } pidc_op_t;

  // Controller to datapath
  typedef struct packed {
    pidc_op_t op;
    logic     load_in;
    logic     load_out;
  } pidc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dt_zero;
    logic div_busy;
  } pidc_sts_t;

  // Magnitude of a signed word; the most negative value maps to 2^(DataW-1)
  function automatic logic [DataW-1:0] mag32(input logic signed [DataW-1:0] x);
    logic [DataW-1:0] neg;
    neg = DataW'(-x);
    return x[DataW-1] ? neg : DataW'(x);
  endfunction

  function automatic logic [IntW-1:0] mag64(input logic signed [IntW-1:0] x);
    logic [IntW-1:0] neg;
    neg = IntW'(-x);
    return x[IntW-1] ? neg : IntW'(x);
  endfunction

endpackage

>>> hdl/pidc_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pidc_pkg for widths.
module pidc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [pidc_pkg::NumW-1:0] num,
  input  logic [pidc_pkg::DtW-1:0]  den,
  output logic                     busy,
  output logic [pidc_pkg::NumW-1:0] quo
);
  import pidc_pkg::*;

  logic            busy_r, busy_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [NumW-1:0] rq_r;    // numerator shifts out, quotient shifts in
  logic [DtW-1:0]  rem_r;
  logic [DtW-1:0]  den_r;

  logic [DtW:0]    shifted;
  logic [DtW+1:0]  trial;
  logic            fits;
  logic [DtW-1:0]  rem_step;

  // One trial subtraction
  always_comb begin
    shifted  = {rem_r, rq_r[NumW-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    fits     = ~trial[DtW+1];
    rem_step = fits ? trial[DtW-1:0] : shifted[DtW-1:0];
  end

  // Step counter
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(DivSteps);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rq_r  <= {rq_r[NumW-2:0], fits};
      rem_r <= rem_step;
    end
  end

  assign busy = busy_r;
  assign quo  = rq_r;

endmodule

>>> hdl/pidc_dp.sv
// PID datapath: config registers, state, shared multiplier, accumulator, clamp.
// Depends on pidc_pkg and pidc_div.
module pidc_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pidc_pkg::pidc_cmd_t    cmd,
  output pidc_pkg::pidc_sts_t    sts,
  input  pidc_pkg::pidc_in_t     in_data,
  input  logic                   cfg_we,
  input  pidc_pkg::reg_idx_t     cfg_index,
  input  logic [pidc_pkg::DataW-1:0] cfg_data,
  output pidc_pkg::pidc_out_t    out_data
);
  import pidc_pkg::*;

  // Configuration
  logic signed [DataW-1:0] kp_r, ki_r, kd_r, out_min_r, out_max_r;

  // Controller state
  logic signed [IntW-1:0]  integral_r;
  logic signed [DataW-1:0] prev_r;

  // Item and working registers
  logic signed [DataW-1:0] err_r;
  logic [DtW-1:0]          dt_r;
  logic [DataW-1:0]        e_mag_r;
  logic [2*DataW-1:0]      prod_r;
  logic signed [IntW-1:0]  acc_r, acc_nxt;
  logic [IntW-1:0]         int_mag_r;
  logic                    int_neg_r;
  logic [DataW-1:0]        der_mag_r;
  logic                    der_neg_r;
  pidc_out_t               out_r;

  logic [DataW-1:0]        mul_a, mul_b;
  logic [DataW:0]          diff;
  logic [DataW:0]          diff_neg_val;
  logic                    diff_neg;
  logic [DataW-1:0]        diff_mag;
  logic                    div_start, div_busy;
  logic [NumW-1:0]         div_quo;
  logic [IntW:0]           int_sum;
  logic signed [IntW-1:0]  int_nxt;
  logic signed [IntW-1:0]  acc_base;
  logic [IntW-1:0]         acc_val;
  logic                    acc_neg;
  logic signed [IntW-1:0]  max64, min64;
  logic                    der_over;
  logic signed [DataW-1:0] drive_lo;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      out_min_r <= OUT_MIN_RST;
      out_max_r <= OUT_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:      kp_r      <= cfg_data;
        REG_KI:      ki_r      <= cfg_data;
        REG_KD:      kd_r      <= cfg_data;
        REG_OUT_MIN: out_min_r <= cfg_data;
        REG_OUT_MAX: out_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Error difference for the derivative
  always_comb begin
    diff         = {err_r[DataW-1], err_r} - {prev_r[DataW-1], prev_r};
    diff_neg     = diff[DataW];
    diff_neg_val = -diff;
    diff_mag     = diff_neg ? diff_neg_val[DataW-1:0] : diff[DataW-1:0];
  end

  assign div_start = (cmd.op == OP_ACC_INT);

  pidc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({diff_mag, {FracW{1'b0}}}),
    .den   (dt_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_EDT: begin
        mul_a = e_mag_r;
        mul_b = DataW'(dt_r);
      end
      OP_MUL_KP: begin
        mul_a = mag32(kp_r);
        mul_b = e_mag_r;
      end
      OP_MUL_KIL: begin
        mul_a = mag32(ki_r);
        mul_b = int_mag_r[DataW-1:0];
      end
      OP_MUL_KIH: begin
        mul_a = mag32(ki_r);
        mul_b = int_mag_r[IntW-1:DataW];
      end
      OP_MUL_KD: begin
        mul_a = mag32(kd_r);
        mul_b = der_mag_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Saturating integral update with error*dt
  always_comb begin
    if (err_r[DataW-1]) begin
      int_sum = {integral_r[IntW-1], integral_r} - {1'b0, prod_r};
    end else begin
      int_sum = {integral_r[IntW-1], integral_r} + {1'b0, prod_r};
    end
    if (int_sum[IntW] != int_sum[IntW-1]) begin
      int_nxt = int_sum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      int_nxt = int_sum[IntW-1:0];
    end
  end

  // Signed accumulate of the scaled product terms
  always_comb begin
    acc_base = acc_r;
    acc_val  = '0;
    acc_neg  = 1'b0;
    unique case (cmd.op)
      OP_ACC_KP: begin
        acc_base = '0;
        acc_val  = prod_r >> FracW;
        acc_neg  = kp_r[DataW-1] ^ err_r[DataW-1];
      end
      OP_ACC_KIL: begin
        acc_val = prod_r >> DataW;
        acc_neg = ki_r[DataW-1] ^ int_neg_r;
      end
      OP_ACC_KIH: begin
        acc_val = prod_r;
        acc_neg = ki_r[DataW-1] ^ int_neg_r;
      end
      OP_ACC_KD: begin
        acc_val = prod_r >> FracW;
        acc_neg = kd_r[DataW-1] ^ der_neg_r;
      end
      default: ;
    endcase
  end

  // Clamp limits and derivative saturation
  always_comb begin
    max64    = IntW'(out_max_r);
    min64    = IntW'(out_min_r);
    der_over = der_neg_r ? (div_quo > NumW'(48'h0000_8000_0000))
                         : (div_quo > NumW'(48'h0000_7FFF_FFFF));
    drive_lo = (acc_r < min64) ? out_min_r : acc_r[DataW-1:0];
    acc_nxt  = acc_neg ? (acc_base - signed'(acc_val)) : (acc_base + signed'(acc_val));
    if (cmd.op == OP_CLAMP_HI) begin
      acc_nxt = (acc_r > max64) ? max64 : acc_r;
    end
  end

  // Controller state: integral and previous error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_r     <= '0;
    end else if (cmd.op == OP_ACC_INT) begin
      integral_r <= int_nxt;
      prev_r     <= err_r;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_r   <= in_data.error;
      dt_r    <= in_data.dt;
      e_mag_r <= mag32(in_data.error);
    end
    if (cmd.op == OP_ACC_INT) begin
      der_neg_r <= diff_neg;
    end
    if (cmd.op == OP_ACC_KP) begin
      int_mag_r <= mag64(integral_r);
      int_neg_r <= integral_r[IntW-1];
    end
    if (cmd.op == OP_LATCH_DER) begin
      if (der_over) begin
        der_mag_r <= der_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        der_mag_r <= div_quo[DataW-1:0];
      end
    end
    if (cmd.op == OP_ACC_KP || cmd.op == OP_ACC_KIL || cmd.op == OP_ACC_KIH ||
        cmd.op == OP_ACC_KD || cmd.op == OP_CLAMP_HI) begin
      acc_r <= acc_nxt;
    end
    if (cmd.load_out) begin
      if (dt_r == '0) begin
        out_r.drive   <= '0;
        out_r.skipped <= 1'b1;
      end else begin
        out_r.drive   <= drive_lo;
        out_r.skipped <= 1'b0;
      end
    end
  end

  assign sts.dt_zero  = (dt_r == '0);
  assign sts.div_busy = div_busy;
  assign out_data     = out_r;

endmodule

>>> hdl/pidc_ctrl.sv
// PID sequencer: steps the datapath through multiply and accumulate ops.
// Depends on pidc_pkg; drives pidc_dp through the command struct.
module pidc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pidc_pkg::pidc_cmd_t cmd,
  input  pidc_pkg::pidc_sts_t sts
);
  import pidc_pkg::*;

  pidc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output slot frees when its transaction completes
  assign slot_free = ~out_valid_r | out_ready;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.load_in  = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = S_MUL_EDT;
      end
      S_MUL_EDT: begin
        cmd.op    = OP_MUL_EDT;
        state_nxt = sts.dt_zero ? S_PUT : S_ACC_INT;
      end
      S_ACC_INT: begin
        cmd.op    = OP_ACC_INT;
        state_nxt = S_MUL_KP;
      end
      S_MUL_KP: begin
        cmd.op    = OP_MUL_KP;
        state_nxt = S_ACC_KP;
      end
      S_ACC_KP: begin
        cmd.op    = OP_ACC_KP;
        state_nxt = S_MUL_KIL;
      end
      S_MUL_KIL: begin
        cmd.op    = OP_MUL_KIL;
        state_nxt = S_ACC_KIL;
      end
      S_ACC_KIL: begin
        cmd.op    = OP_ACC_KIL;
        state_nxt = S_MUL_KIH;
      end
      S_MUL_KIH: begin
        cmd.op    = OP_MUL_KIH;
        state_nxt = S_ACC_KIH;
      end
      S_ACC_KIH: begin
        cmd.op    = OP_ACC_KIH;
        state_nxt = S_WAIT_DIV;
      end
      S_WAIT_DIV: begin
        cmd.op = OP_LATCH_DER;
        if (!sts.div_busy) state_nxt = S_MUL_KD;
      end
      S_MUL_KD: begin
        cmd.op    = OP_MUL_KD;
        state_nxt = S_ACC_KD;
      end
      S_ACC_KD: begin
        cmd.op    = OP_ACC_KD;
        state_nxt = S_CLAMP_HI;
      end
      S_CLAMP_HI: begin
        cmd.op    = OP_CLAMP_HI;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cmd.load_out = slot_free;
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/pid_controller_clamped_unit.sv
// Fixed-point PID controller with output clamp, valid/ready channels.
// Depends on pidc_pkg, pidc_ctrl, pidc_dp (which holds pidc_div).
//
// One transaction in gives one transaction out. A sample with dt of zero
// returns drive 0 with skipped set and leaves the integral and previous
// error alone. Any other sample has its result paced by the 48-step
// restoring divider that forms (error - previous error) / dt; the five
// products share one 32x32 multiplier that runs alongside it. One sample
// is processed at a time; a finished result waits in the output register,
// so the next sample can be accepted while it is still pending. Config
// writes are always taken (cfg_ready is tied high) and must come only while
// the block is idle; writes to indexes above 4 are dropped.
module pid_controller_clamped_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pidc_pkg::pidc_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pidc_pkg::pidc_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  pidc_pkg::reg_idx_t         cfg_index,
  input  logic [pidc_pkg::DataW-1:0] cfg_data
);
  import pidc_pkg::*;

  pidc_cmd_t cmd;
  pidc_sts_t sts;

  assign cfg_ready = 1'b1;

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pidc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

>>> hdl/pidc_checker.sv
// Port-level checks for the PID controller, bound to the top level.
// Depends on pidc_pkg and pid_controller_clamped_unit_macros.svh.
`include "pid_controller_clamped_unit_macros.svh"

module pidc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input pidc_pkg::pidc_out_t        out_data,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input pidc_pkg::reg_idx_t         cfg_index,
  input logic [pidc_pkg::DataW-1:0] cfg_data
);
  import pidc_pkg::*;

  logic [1:0]              pend_r, pend_nxt;
  logic signed [DataW-1:0] min_r, max_r;
  logic                    in_acc, out_acc;
  logic                    out_stall, skip_out, clamp_chk, drive_in;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // Qualifiers for the result checks
  assign out_stall = out_valid & ~out_ready;
  assign skip_out  = out_valid & out_data.skipped;
  assign clamp_chk = out_valid && !out_data.skipped && min_r <= max_r;
  assign drive_in  = out_data.drive >= min_r && out_data.drive <= max_r;

  // Transactions accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 2'd1;
    if (!in_acc && out_acc) pend_nxt = pend_r - 2'd1;
  end

  // Pending count and shadow copies of the clamp limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      min_r  <= OUT_MIN_RST;
      max_r  <= OUT_MAX_RST;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_valid && cfg_ready && cfg_index == REG_OUT_MIN) min_r <= cfg_data;
      if (cfg_valid && cfg_ready && cfg_index == REG_OUT_MAX) max_r <= cfg_data;
    end
  end

  `PIDC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result changed in stall")
  `PIDC_ASSERT_NOW(a_no_orphan, out_valid, pend_r != 2'd0, "result without an accepted sample")
  `PIDC_ASSERT_NOW(a_no_overrun, in_acc, pend_r != 2'd2, "sample accepted with two results pending")
  `PIDC_ASSERT_NOW(a_skip_zero, skip_out, out_data.drive == '0, "skipped result with nonzero drive")
  `PIDC_ASSERT_NOW(a_in_limits, clamp_chk, drive_in, "drive outside clamp limits")

endmodule

bind pid_controller_clamped_unit pidc_checker u_pidc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

>>> bench/pid_controller_clamped_unit_tb.sv
// Self-checking bench for pid_controller_clamped_unit: a directed table, then random samples.
// Needs pidc_pkg and the RTL of the block; checks each result against a typed-in value or a local fixed-point model.
module pid_controller_clamped_unit_tb;
  import pidc_pkg::*;

  // Register indexes past the last register; writes there must be dropped
  localparam reg_idx_t REG_SPARE_FIRST = reg_idx_t'(5);
  localparam reg_idx_t REG_SPARE_LAST  = reg_idx_t'(7);

  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;
  localparam longint AccMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint AccMin  = 64'sh8000_0000_0000_0000;

  localparam int DirRows   = 28;
  localparam int PhaseLen  = 184;
  localparam int ClimbPct  = 85;
  localparam int DrainWait = 64;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  pidc_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  pidc_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  reg_idx_t         cfg_index = '0;
  logic [DataW-1:0] cfg_data  = '0;

  pid_controller_clamped_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the registers and of the controller state
  longint gain_p, gain_i, gain_d, lim_lo, lim_hi;
  longint integ_acc, last_err;

  pidc_out_t pending_drives[$];
  int        send_idle_pct = 23;
  int        recv_idle_pct = 72;
  int        mismatches    = 0;

  // Directed rows: a register write or a sample, with the result typed in where obvious
  typedef struct packed {
    logic        is_cfg;
    reg_idx_t    idx;
    logic [31:0] word;
    logic [23:0] dt;
    logic        known;
    logic [31:0] drive;
    logic        skipped;
  } stim_row_t;

  stim_row_t dir_tab [DirRows] = '{
    // reset gains are zero, so any timed sample gives zero
    '{1'b0, '0, 32'h7FFF_FFFF, 24'h00_0001, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, '0, 32'h8000_0000, 24'hFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, '0, 32'h1234_5678, 24'h00_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, '0, 32'h0000_0000, 24'h80_0000, 1'b1, 32'h0000_0000, 1'b0},
    // extreme gains and the widest limits
    '{1'b1, REG_KP,          32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_KI,          32'h8000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_KD,          32'h8000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_OUT_MIN,     32'h8000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_OUT_MAX,     32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_SPARE_FIRST, 32'h0000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_SPARE_LAST,  32'h0000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b0, '0, 32'h8000_0000, 24'hFF_FFFF, 1'b0, '0, 1'b0},
    '{1'b0, '0, 32'h7FFF_FFFF, 24'h00_0001, 1'b0, '0, 1'b0},
    '{1'b0, '0, 32'h8000_0000, 24'h00_0001, 1'b0, '0, 1'b0},
    '{1'b0, '0, 32'h0000_0000, 24'h00_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, '0, 32'h0001_0000, 24'hFF_FFFF, 1'b0, '0, 1'b0},
    // inverted limits pin the drive at the lower limit
    '{1'b1, REG_OUT_MIN,     32'h0002_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_OUT_MAX,     32'hFFFE_0000, '0, 1'b0, '0, 1'b0},
    '{1'b0, '0, 32'h7FFF_FFFF, 24'h7F_FFFF, 1'b1, 32'h0002_0000, 1'b0},
    '{1'b0, '0, 32'h8000_0000, 24'h00_0001, 1'b1, 32'h0002_0000, 1'b0},
    '{1'b0, '0, 32'hFFFF_FFFF, 24'h00_0000, 1'b1, 32'h0000_0000, 1'b1},
    // unity proportional gain alone passes the error through
    '{1'b1, REG_KP,          32'h0001_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_KI,          32'h0000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_KD,          32'h0000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_OUT_MIN,     32'h8000_0000, '0, 1'b0, '0, 1'b0},
    '{1'b1, REG_OUT_MAX,     32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0},
    '{1'b0, '0, 32'h0001_2345, 24'h00_0100, 1'b1, 32'h0001_2345, 1'b0},
    '{1'b0, '0, 32'hFFFF_0000, 24'hFF_FFFF, 1'b1, 32'hFFFF_0000, 1'b0}
  };

  function automatic logic [63:0] abs64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // Q16.16 times Q16.16: drop 16 fraction bits, truncating toward zero
  function automatic longint scale_q16(longint a, longint b);
    logic [63:0] m;
    m = (abs64(a) * abs64(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Q16.16 gain times Q32.32 integral: drop 32 fraction bits, toward zero
  function automatic longint scale_integ(longint g, longint s);
    logic [127:0] p;
    p = {64'd0, abs64(g)} * {64'd0, abs64(s)};
    return ((g < 0) != (s < 0)) ? -longint'(p[95:32]) : longint'(p[95:32]);
  endfunction

  // Expected result of one sample; advances integral and previous error
  function automatic pidc_out_t next_drive(pidc_in_t s);
    pidc_out_t r;
    int        e32;
    longint    err, span, inc, sum, slope, y;
    r = '0;
    if (s.dt == '0) begin
      r.skipped = 1'b1;
      return r;
    end
    e32  = s.error;
    err  = e32;
    span = longint'({40'd0, s.dt});
    // integral saturates at the 64-bit limits
    inc = err * span;
    sum = integ_acc + inc;
    if (integ_acc[63] == inc[63] && sum[63] != inc[63])
      sum = inc[63] ? AccMin : AccMax;
    integ_acc = sum;
    // derivative in Q16.16, truncated toward zero, saturated to 32 bits
    slope = ((err - last_err) * 65536) / span;
    if (slope > WordMax)
      slope = WordMax;
    if (slope < WordMin)
      slope = WordMin;
    y = scale_q16(gain_p, err) + scale_integ(gain_i, integ_acc) + scale_q16(gain_d, slope);
    if (y > lim_hi)
      y = lim_hi;
    if (y < lim_lo)
      y = lim_lo;
    last_err = err;
    r.drive  = y[31:0];
    return r;
  endfunction

  // Random sample: mostly a wind-up push in one direction, the rest noise
  function automatic pidc_in_t pick_sample(bit upward);
    pidc_in_t    s;
    int unsigned mag;
    if ($urandom_range(99) < ClimbPct) begin
      mag     = $urandom_range(24'hFF_FFFF);
      s.error = upward ? 32'h7FFF_FFFF - mag : 32'h8000_0000 + mag;
      s.dt    = 24'hFF_FFFF - 24'($urandom_range(20'hF_FFFF));
    end else begin
      s.error = $urandom;
      case ($urandom_range(4))
        0:       s.dt = '0;
        1:       s.dt = 24'($urandom_range(255));
        default: s.dt = 24'($urandom);
      endcase
    end
    return s;
  endfunction

  // One sample transaction; the expectation is queued at acceptance
  task automatic send_sample(pidc_in_t s, logic typed, pidc_out_t typed_res);
    pidc_out_t model_res;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    model_res = next_drive(s);
    pending_drives.push_back(typed ? typed_res : model_res);
  endtask

  // Register write transaction; valid stays up for a following write
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    int v;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    v = val;
    case (idx)
      REG_KP:      gain_p = v;
      REG_KI:      gain_i = v;
      REG_KD:      gain_d = v;
      REG_OUT_MIN: lim_lo = v;
      REG_OUT_MAX: lim_hi = v;
      default: ;
    endcase
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    pidc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: drive %h skipped %0b", out_data.drive, out_data.skipped);
      end else begin
        want = pending_drives.pop_front();
        if (out_data.drive !== want.drive || out_data.skipped !== want.skipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: drive exp %h got %h, skipped exp %0b got %0b",
                     want.drive, out_data.drive, want.skipped, out_data.skipped);
        end
      end
    end
  end

  initial begin : stimulus
    pidc_in_t  smp;
    pidc_out_t typed_res;
    gain_p    = 0;
    gain_i    = 0;
    gain_d    = 0;
    lim_lo    = longint'(OUT_MIN_RST);
    lim_hi    = longint'(OUT_MAX_RST);
    integ_acc = 0;
    last_err  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].word);
      end else begin
        smp.error         = dir_tab[i].word;
        smp.dt            = dir_tab[i].dt;
        typed_res.drive   = dir_tab[i].drive;
        typed_res.skipped = dir_tab[i].skipped;
        send_sample(smp, dir_tab[i].known, typed_res);
      end
    end

    // Random phases, each with fresh register settings
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      if (phase == 1) begin
        send_idle_pct = 72;
        recv_idle_pct = 23;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin
          write_reg(REG_KP, 32'(int'($urandom_range(262143)) - 131072));
          write_reg(REG_KI, 32'(int'($urandom_range(7)) - 4));
          write_reg(REG_KD, 32'(int'($urandom_range(262143)) - 131072));
          write_reg(REG_OUT_MIN, 32'h8000_0000);
          write_reg(REG_OUT_MAX, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(REG_KP, $urandom);
          write_reg(REG_KI, $urandom);
          write_reg(REG_KD, $urandom);
          write_reg(REG_OUT_MIN, 32'h8000_0000 | $urandom);
          write_reg(REG_OUT_MAX, 32'($urandom_range(32'h7FFF_FFFF)));
        end
        default: begin
          write_reg(REG_KP, 32'(int'($urandom_range(131071)) - 65536));
          write_reg(REG_KI, 32'(int'($urandom_range(3)) - 2));
          write_reg(REG_KD, 32'(int'($urandom_range(4095)) - 2048));
          write_reg(REG_OUT_MIN, OUT_MIN_RST);
          write_reg(REG_OUT_MAX, OUT_MAX_RST);
        end
      endcase
      write_reg(reg_idx_t'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), $urandom);
      // first two phases wind the integral up, the last one back down
      repeat (PhaseLen) send_sample(pick_sample(phase < 2), 1'b0, '0);
    end

    drain();
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/pidc_pkg.sv
hdl/pidc_div.sv
hdl/pidc_dp.sv
hdl/pidc_ctrl.sv
hdl/pid_controller_clamped_unit.sv
hdl/pidc_checker.sv
bench/pid_controller_clamped_unit_tb.sv
